[rtl/lapg_pkg.sv]
// Shared types, constants and small lookup functions for the LED pattern generator.
// No dependencies; every other file imports this package.
package lapg_pkg;

  localparam int unsigned LED_COUNT = 64;
  localparam int CW = $clog2(LED_COUNT) + 2;

  // animation mode codes
  localparam logic [3:0] MODE_OFF      = 4'd0;
  localparam logic [3:0] MODE_SOLID    = 4'd1;
  localparam logic [3:0] MODE_FLASH    = 4'd2;
  localparam logic [3:0] MODE_SOS      = 4'd3;
  localparam logic [3:0] MODE_FADE_Y   = 4'd4;
  localparam logic [3:0] MODE_FADE_RGB = 4'd5;
  localparam logic [3:0] MODE_RAINBOW  = 4'd6;
  localparam logic [3:0] MODE_BREATH   = 4'd7;
  localparam logic [3:0] MODE_CHASE    = 4'd8;
  localparam logic [3:0] MODE_WAVE     = 4'd9;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_PERIOD = 3'd1;
  localparam logic [2:0] CFG_RED    = 3'd2;
  localparam logic [2:0] CFG_GREEN  = 3'd3;
  localparam logic [2:0] CFG_BLUE   = 3'd4;
  localparam logic [2:0] CFG_FLASH  = 3'd5;

  localparam logic [15:0] SOS_PERIOD = 16'd5400;
  localparam logic [16:0] FADE_A     = 17'd21627;
  localparam logic [16:0] FADE_B     = 17'd43254;
  localparam logic [16:0] FADE_W3    = 17'd22282;
  localparam logic [17:0] RECIP_A    = 18'((64'd1 << 32) / 64'(FADE_A));
  localparam logic [17:0] RECIP_W3   = 18'((64'd1 << 32) / 64'(FADE_W3));
  localparam logic [17:0] WAVE_STEP  = 18'd133509;

  typedef struct packed {
    logic [5:0]  led_index;
    logic [31:0] elapsed_ms;
  } lapg_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } lapg_out_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] period_ms;
    logic [7:0]  solid_red;
    logic [7:0]  solid_green;
    logic [7:0]  solid_blue;
    logic [3:0]  flash_rate_hz;
  } lapg_cfg_t;

  typedef struct packed {
    logic [5:0]  led_index;
    logic [15:0] phase;
    logic [12:0] sos_t;
  } lapg_phase_t;

  typedef struct packed {
    lapg_phase_t base;
    logic [2:0]  rb_sector;
    logic [15:0] rb_f;
    logic        chase_hit;
    logic [2:0]  chase_k;
  } lapg_side_t;

  typedef struct packed {
    lapg_side_t  side;
    logic [16:0] ease;
    logic [15:0] wave_x;
  } lapg_shade_t;

  // quarter-wave sine, 0.15
  function automatic logic [14:0] sine_tab(input logic [4:0] k);
    case (k)
      5'd0:    return 15'd0;
      5'd1:    return 15'd3212;
      5'd2:    return 15'd6393;
      5'd3:    return 15'd9512;
      5'd4:    return 15'd12539;
      5'd5:    return 15'd15446;
      5'd6:    return 15'd18204;
      5'd7:    return 15'd20787;
      5'd8:    return 15'd23170;
      5'd9:    return 15'd25329;
      5'd10:   return 15'd27245;
      5'd11:   return 15'd28898;
      5'd12:   return 15'd30273;
      5'd13:   return 15'd31356;
      5'd14:   return 15'd32137;
      5'd15:   return 15'd32609;
      5'd16:   return 15'd32767;
      default: return 15'd0;
    endcase
  endfunction

  // floor(255 * x / 65536)
  function automatic logic [7:0] level(input logic [16:0] x);
    logic [24:0] prod;
    prod = {x, 8'b0} - {8'b0, x};
    return prod[23:16];
  endfunction

  // flash period, rate clamped to 1..10
  function automatic logic [15:0] flash_period(input logic [3:0] rate);
    case (rate)
      4'd0, 4'd1: return 16'(1000 / 1);
      4'd2:       return 16'(1000 / 2);
      4'd3:       return 16'(1000 / 3);
      4'd4:       return 16'(1000 / 4);
      4'd5:       return 16'(1000 / 5);
      4'd6:       return 16'(1000 / 6);
      4'd7:       return 16'(1000 / 7);
      4'd8:       return 16'(1000 / 8);
      4'd9:       return 16'(1000 / 9);
      default:    return 16'(1000 / 10);
    endcase
  endfunction

  // S-O-S on windows within the 5400 ms frame
  function automatic logic sos_on(input logic [12:0] t);
    return (t < 13'd200) ||
           (t >= 13'd400  && t < 13'd600)  ||
           (t >= 13'd800  && t < 13'd1000) ||
           (t >= 13'd1600 && t < 13'd2200) ||
           (t >= 13'd2400 && t < 13'd3000) ||
           (t >= 13'd3200 && t < 13'd3800) ||
           (t >= 13'd4400 && t < 13'd4600) ||
           (t >= 13'd4800 && t < 13'd5000) ||
           (t >= 13'd5200 && t < 13'd5400);
  endfunction

endpackage

[rtl/led_animation_pattern_generator_core.sv]
// Top level of the LED pattern generator: config registers, period select, pipeline.
// Instantiates lapg_phase_div, lapg_wave and lapg_color; uses lapg_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one transaction per LED,
//    carrying the LED index and milliseconds since the animation started.
//  - Output channel (out_valid / out_stall / out_data): one transaction per
//    input, the 8-bit red, green and blue of that LED, in input order.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
//    mode, period, solid color and flash rate. cfg_ready is always high.
//    Write only while no transaction is in flight.
//  - Pipeline: 12 divider stages (four quotient bits each), 5 sine/ease
//    stages, 4 color stages.
//  - Throughput: one transaction per cycle; every stage is registered and a
//    new item enters each cycle the pipeline is moving.
//  - Stall: out_stall holds the output register; bubbles inside the pipeline
//    still close up, and in_stall rises only once every stage holds an item.
//  - Reset (rst_n low, synchronous): pipeline empties, config returns to
//    mode solid, period 2000 ms, white, flash 2 Hz.
module led_animation_pattern_generator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lapg_pkg::lapg_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lapg_pkg::lapg_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import lapg_pkg::*;

  lapg_cfg_t   cfg_r, cfg_nxt;
  logic [15:0] period;

  logic        div_in_ready;
  logic        ph_valid, ph_ready;
  lapg_phase_t ph_data;
  logic        sh_valid, sh_ready;
  lapg_shade_t sh_data;

  assign cfg_ready = 1'b1;

  // register write decode; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:   cfg_nxt.mode          = cfg_data[3:0];
        CFG_PERIOD: cfg_nxt.period_ms     = cfg_data;
        CFG_RED:    cfg_nxt.solid_red     = cfg_data[7:0];
        CFG_GREEN:  cfg_nxt.solid_green   = cfg_data[7:0];
        CFG_BLUE:   cfg_nxt.solid_blue    = cfg_data[7:0];
        CFG_FLASH:  cfg_nxt.flash_rate_hz = cfg_data[3:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode          <= MODE_SOLID;
      cfg_r.period_ms     <= 16'd2000;
      cfg_r.solid_red     <= 8'd255;
      cfg_r.solid_green   <= 8'd255;
      cfg_r.solid_blue    <= 8'd255;
      cfg_r.flash_rate_hz <= 4'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // period: fixed for SOS, table for flash, else register (zero reads as one)
  always_comb begin
    case (cfg_r.mode)
      MODE_SOS:   period = SOS_PERIOD;
      MODE_FLASH: period = flash_period(cfg_r.flash_rate_hz);
      default:    period = (cfg_r.period_ms == 16'd0) ? 16'd1 : cfg_r.period_ms;
    endcase
  end

  lapg_phase_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (div_in_ready),
    .in_data   (in_data),
    .period    (period),
    .out_valid (ph_valid),
    .out_ready (ph_ready),
    .out_data  (ph_data)
  );

  lapg_wave u_wave (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (ph_valid),
    .in_ready  (ph_ready),
    .in_data   (ph_data),
    .out_valid (sh_valid),
    .out_ready (sh_ready),
    .out_data  (sh_data)
  );

  lapg_color u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (sh_valid),
    .in_ready  (sh_ready),
    .in_data   (sh_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !div_in_ready;

  // input backs up only when the whole pipe is full behind a stalled output
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline could advance");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_index == CFG_MODE) |=> (cfg_r.mode == $past(cfg_data[3:0])))
    else $error("mode register write lost");

endmodule

[rtl/lapg_phase_div.sv]
// Pipelined restoring divider: {elapsed, 16'b0} / period, 4 quotient bits per stage.
// Gives the 0.16 phase and the elapsed-mod-period remainder. Uses lapg_pkg.
module lapg_phase_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lapg_pkg::lapg_in_t    in_data,
  input  logic [15:0]           period,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lapg_pkg::lapg_phase_t out_data
);
  import lapg_pkg::*;

  localparam int NS    = 12;
  localparam int SPLIT = 8;   // stages that consume the elapsed bits

  logic [NS-1:0] v_r;
  logic [15:0]   rem_r [NS];
  logic [47:0]   dvd_r [NS];
  logic [15:0]   q_r   [NS];
  logic [5:0]    idx_r [NS];
  logic [12:0]   sos_r [NS];
  logic [NS:0]   rdy;

  logic          v_in   [NS];
  logic [15:0]   rem_in [NS];
  logic [47:0]   dvd_in [NS];
  logic [15:0]   q_in   [NS];
  logic [5:0]    idx_in [NS];
  logic [12:0]   sos_in [NS];
  logic [19:0]   step   [NS];

  function automatic logic [19:0] div4(input logic [15:0] rem, input logic [3:0] bits,
                                       input logic [15:0] per);
    logic [16:0] acc;
    logic [15:0] r;
    logic [3:0]  q;
    r = rem;
    q = '0;
    for (int i = 3; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, per}) begin
        r    = 16'(acc - {1'b0, per});
        q[i] = 1'b1;
      end else begin
        r = acc[15:0];
      end
    end
    return {r, q};
  endfunction

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        v_in[k]   = in_valid;
        rem_in[k] = '0;
        dvd_in[k] = {in_data.elapsed_ms, 16'b0};
        q_in[k]   = '0;
        idx_in[k] = in_data.led_index;
        sos_in[k] = '0;
      end else begin
        v_in[k]   = v_r[k-1];
        rem_in[k] = rem_r[k-1];
        dvd_in[k] = dvd_r[k-1];
        q_in[k]   = q_r[k-1];
        idx_in[k] = idx_r[k-1];
        sos_in[k] = sos_r[k-1];
      end
      step[k] = div4(rem_in[k], dvd_in[k][47:44], period);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in[k];
      end
      if (rdy[k]) begin
        rem_r[k] <= step[k][19:4];
        q_r[k]   <= {q_in[k][11:0], step[k][3:0]};
        dvd_r[k] <= dvd_in[k] << 4;
        idx_r[k] <= idx_in[k];
        if (k == SPLIT - 1) begin
          sos_r[k] <= step[k][16:4];
        end else begin
          sos_r[k] <= sos_in[k];
        end
      end
    end
  end

  assign in_ready           = rdy[0];
  assign out_valid          = v_r[NS-1];
  assign out_data.led_index = idx_r[NS-1];
  assign out_data.phase     = q_r[NS-1];
  assign out_data.sos_t     = sos_r[NS-1];

  a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> (rem_r[NS-1] < period))
    else $error("divider remainder not below period");

endmodule

[rtl/lapg_wave.sv]
// Sine, hue, chase and ease stages: five pipeline stages from phase to eased value.
// Uses lapg_pkg.
module lapg_wave (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lapg_pkg::lapg_cfg_t   cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lapg_pkg::lapg_phase_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lapg_pkg::lapg_shade_t out_data
);
  import lapg_pkg::*;

  logic [4:0] v_r;
  logic [5:0] rdy;

  lapg_side_t  side_r1, side_r2, side_r3, side_r4;
  logic [14:0] base_r1;
  logic [11:0] diff_r1;
  logic [9:0]  frac_r1;
  logic        neg_r1;
  logic [15:0] ein_r2, wx_r2, wx_r3, wx_r4;
  logic [15:0] w_r3;
  logic        hi_r3, hi_r4;
  logic [31:0] sq_r3;
  logic [15:0] c_r4;
  lapg_shade_t out_r5;

  // stage 1 logic
  logic [15:0]   hue, hue_off, wave_off, angle;
  logic [18:0]   h6;
  logic [CW-1:0] pos, dd;
  logic [14:0]   r14;
  logic [4:0]    sidx;
  logic [14:0]   base_nxt;
  logic [11:0]   diff_nxt;
  lapg_side_t    side_nxt;

  always_comb begin
    hue_off  = 16'((32'(in_data.led_index) << 16) / LED_COUNT);
    hue      = in_data.phase + hue_off;
    h6       = {1'b0, hue, 2'b0} + {2'b0, hue, 1'b0};
    pos      = CW'((32'(in_data.phase) * LED_COUNT) >> 16);
    dd       = CW'(in_data.led_index) + CW'(LED_COUNT) - pos;
    if (dd >= CW'(LED_COUNT)) begin
      dd = dd - CW'(LED_COUNT);
    end
    wave_off = 16'((24'(in_data.led_index) * 24'(WAVE_STEP)) >> 6);
    angle    = (cfg.mode == MODE_WAVE) ? in_data.phase + wave_off : in_data.phase;
    r14      = {1'b0, angle[13:0]};
    if (angle[14]) begin
      r14 = 15'd16384 - r14;
    end
    sidx = r14[14:10];
    if (sidx >= 5'd16) begin
      base_nxt = sine_tab(5'd16);
      diff_nxt = '0;
    end else begin
      base_nxt = sine_tab(sidx);
      diff_nxt = 12'(sine_tab(sidx + 5'd1) - sine_tab(sidx));
    end
    side_nxt.base      = in_data;
    side_nxt.rb_sector = h6[18:16];
    side_nxt.rb_f      = h6[15:0];
    side_nxt.chase_hit = dd < CW'(5);
    side_nxt.chase_k   = 3'(CW'(5) - dd);
  end

  // stage 2 logic
  logic [21:0] interp;
  logic [14:0] sval;
  logic [15:0] sx;
  always_comb begin
    interp = 22'(diff_r1) * 22'(frac_r1);
    sval   = base_r1 + 15'(interp >> 10);
    sx     = neg_r1 ? 16'd32768 - {1'b0, sval} : 16'd32768 + {1'b0, sval};
  end

  // stage 3 logic
  logic        hi_nxt;
  logic [15:0] w_nxt;
  always_comb begin
    hi_nxt = ein_r2[15];
    w_nxt  = hi_nxt ? 16'(17'h10000 - {1'b0, ein_r2}) : ein_r2;
  end

  // stage 4 logic
  logic [45:0] cube;
  assign cube = 46'(sq_r3) * 46'(w_r3);

  always_comb begin
    rdy[5] = out_ready;
    for (int k = 4; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_r1 <= side_nxt;
      base_r1 <= base_nxt;
      diff_r1 <= diff_nxt;
      frac_r1 <= r14[9:0];
      neg_r1  <= angle[15];
    end
    if (rdy[1]) begin
      side_r2 <= side_r1;
      ein_r2  <= (cfg.mode == MODE_BREATH) ? sx : side_r1.base.phase;
      wx_r2   <= sx;
    end
    if (rdy[2]) begin
      side_r3 <= side_r2;
      wx_r3   <= wx_r2;
      w_r3    <= w_nxt;
      hi_r3   <= hi_nxt;
      sq_r3   <= 32'(w_nxt) * 32'(w_nxt);
    end
    if (rdy[3]) begin
      side_r4 <= side_r3;
      wx_r4   <= wx_r3;
      hi_r4   <= hi_r3;
      c_r4    <= cube[45:30];
    end
    if (rdy[4]) begin
      out_r5.side   <= side_r4;
      out_r5.wave_x <= wx_r4;
      out_r5.ease   <= hi_r4 ? 17'h10000 - {1'b0, c_r4} : {1'b0, c_r4};
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[4];
  assign out_data  = out_r5;

endmodule

[rtl/lapg_color.sv]
// Fade segment division by constant widths and the final per-mode color select.
// Four stages, the last is the output register. Uses lapg_pkg.
module lapg_color (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lapg_pkg::lapg_cfg_t   cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lapg_pkg::lapg_shade_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lapg_pkg::lapg_out_t   out_data
);
  import lapg_pkg::*;

  localparam logic [1:0] SEG_RG = 2'd0;
  localparam logic [1:0] SEG_GB = 2'd1;
  localparam logic [1:0] SEG_BR = 2'd2;

  logic [3:0] v_r;
  logic [4:0] rdy;

  lapg_shade_t sh_r1, sh_r2, sh_r3;
  logic [32:0] prod_r1;
  logic [14:0] d_r1, d_r2;
  logic [1:0]  seg_r1, seg_r2, seg_r3;
  logic [16:0] q0_r2;
  logic [31:0] qw_r2;
  logic [16:0] t_r3;
  lapg_out_t   out_r4;

  // stage 1: segment and reciprocal product
  logic [1:0]  seg_nxt;
  logic [14:0] d_nxt;
  always_comb begin
    if (in_data.ease < FADE_A) begin
      seg_nxt = SEG_RG;
      d_nxt   = in_data.ease[14:0];
    end else if (in_data.ease < FADE_B) begin
      seg_nxt = SEG_GB;
      d_nxt   = 15'(in_data.ease - FADE_A);
    end else begin
      seg_nxt = SEG_BR;
      d_nxt   = 15'(in_data.ease - FADE_B);
    end
  end

  // stage 2/3: back-multiply and one-step correction
  logic [14:0] wid2, wid3;
  logic [31:0] rem3;
  logic [16:0] t_nxt;
  always_comb begin
    wid2  = (seg_r1 == SEG_BR) ? FADE_W3[14:0] : FADE_A[14:0];
    wid3  = (seg_r2 == SEG_BR) ? FADE_W3[14:0] : FADE_A[14:0];
    rem3  = {1'b0, d_r2, 16'b0} - qw_r2;
    t_nxt = q0_r2 + 17'(rem3 >= 32'(wid3));
    if (t_nxt > 17'h10000) t_nxt = 17'h10000;
  end

  // stage 4: color select
  logic [7:0] lt, lnt, lrb, lw;
  lapg_out_t  col;
  always_comb begin
    lt  = level(t_r3);
    lnt = level(17'h10000 - t_r3);
    lrb = sh_r3.side.rb_sector[0] ? level(17'h10000 - {1'b0, sh_r3.side.rb_f})
                                  : level({1'b0, sh_r3.side.rb_f});
    lw  = level({1'b0, sh_r3.wave_x});
    col = '0;
    case (cfg.mode)
      MODE_SOLID: begin
        col = {cfg.solid_red, cfg.solid_green, cfg.solid_blue};
      end
      MODE_FLASH: begin
        if (!sh_r3.side.base.phase[15]) col = {cfg.solid_red, cfg.solid_green, cfg.solid_blue};
      end
      MODE_SOS: begin
        if (sos_on(sh_r3.side.base.sos_t)) col.out_red = 8'd255;
      end
      MODE_FADE_Y: begin
        col.out_red   = level(17'h10000 - sh_r3.ease);
        col.out_green = col.out_red;
      end
      MODE_FADE_RGB: begin
        case (seg_r3)
          SEG_RG:  begin col.out_red = lnt; col.out_green = lt; end
          SEG_GB:  begin col.out_green = lnt; col.out_blue = lt; end
          default: begin col.out_red = lt; col.out_blue = lnt; end
        endcase
      end
      MODE_RAINBOW: begin
        case (sh_r3.side.rb_sector)
          3'd0:    begin col.out_red = 8'd255; col.out_green = lrb; end
          3'd1:    begin col.out_red = lrb; col.out_green = 8'd255; end
          3'd2:    begin col.out_green = 8'd255; col.out_blue = lrb; end
          3'd3:    begin col.out_green = lrb; col.out_blue = 8'd255; end
          3'd4:    begin col.out_red = lrb; col.out_blue = 8'd255; end
          default: begin col.out_red = 8'd255; col.out_blue = lrb; end
        endcase
      end
      MODE_BREATH: begin
        col.out_red   = level(sh_r3.ease);
        col.out_green = col.out_red;
        col.out_blue  = col.out_red;
      end
      MODE_CHASE: begin
        if (sh_r3.side.chase_hit) begin
          col.out_red   = 8'(sh_r3.side.chase_k) * 8'd51;
          col.out_green = 8'(sh_r3.side.chase_k) * 8'd20;
        end
      end
      MODE_WAVE: begin
        col.out_red  = lw;
        col.out_blue = 8'd255 - lw;
      end
      default: col = '0;
    endcase
    if (32'(sh_r3.side.base.led_index) >= LED_COUNT) col = '0;
  end

  always_comb begin
    rdy[4] = out_ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sh_r1   <= in_data;
      seg_r1  <= seg_nxt;
      d_r1    <= d_nxt;
      prod_r1 <= 33'(d_nxt) * 33'((seg_nxt == SEG_BR) ? RECIP_W3 : RECIP_A);
    end
    if (rdy[1]) begin
      sh_r2  <= sh_r1;
      seg_r2 <= seg_r1;
      d_r2   <= d_r1;
      q0_r2  <= prod_r1[32:16];
      qw_r2  <= 32'(prod_r1[32:16]) * 32'(wid2);
    end
    if (rdy[2]) begin
      sh_r3  <= sh_r2;
      seg_r3 <= seg_r2;
      t_r3   <= t_nxt;
    end
    if (rdy[3]) begin
      out_r4 <= col;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[3];
  assign out_data  = out_r4;

  a_seg_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> (t_r3 <= 17'h10000))
    else $error("fade segment fraction out of range");

endmodule

[tb/sv/led_animation_pattern_generator_core_test.sv]
// Self-checking testbench for the LED animation pattern generator core.
// Depends on lapg_pkg and led_animation_pattern_generator_core; includes a color scoreboard.
`timescale 1ns / 100ps

module led_animation_pattern_generator_core_test;
  import lapg_pkg::*;

  localparam int PIPE_LAT  = 21;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 1300;

  // Quarter-wave sine table, 1.15.
  localparam logic [15:0] QSIN [0:16] = '{
    16'd0, 16'd3212, 16'd6393, 16'd9512, 16'd12539, 16'd15446, 16'd18204,
    16'd20787, 16'd23170, 16'd25329, 16'd27245, 16'd28898, 16'd30273,
    16'd31356, 16'd32137, 16'd32609, 16'd32767
  };

  // --------------------------------------------------------------------
  // Color prediction. Config shadow lives in the scoreboard.
  // --------------------------------------------------------------------
  function automatic logic [16:0] eased(input logic [16:0] t);
    logic [63:0] w;
    if (t < 17'd32768) begin
      w = t;
      return 17'((64'd4 * w * w * w) >> 32);
    end
    w = 64'd65536 - t;
    return 17'(64'd65536 - ((64'd4 * w * w * w) >> 32));
  endfunction

  function automatic logic [7:0] lvl(input logic [16:0] x);
    return 8'((32'd255 * x) >> 16);
  endfunction

  // (sin + 1)/2 as 0.16, angle in 0.16 turns
  function automatic logic [16:0] half_sine(input logic [15:0] a);
    logic [1:0]  quad;
    logic [14:0] r;
    logic [31:0] v;
    quad = a[15:14];
    r = {1'b0, a[13:0]};
    if (quad[0]) r = 15'd16384 - r;
    if (r[14:10] >= 5'd16) v = QSIN[16];
    else v = QSIN[r[14:10]] +
             (((QSIN[r[14:10] + 1] - QSIN[r[14:10]]) * r[9:0]) >> 10);
    return quad[1] ? 17'(32768 - v) : 17'(32768 + v);
  endfunction

  function automatic logic [16:0] seg_frac(input logic [16:0] d, input logic [16:0] w);
    logic [63:0] t;
    t = (64'(d) << 16) / w;
    return (t > 64'd65536) ? 17'd65536 : 17'(t);
  endfunction

  function automatic logic sos_lit(input int unsigned t);
    if (t < 1000) return (t / 200) % 2 == 0;
    if (t < 1600) return 1'b0;
    if (t < 3800) return ((t - 1600) % 800) < 600;
    if (t < 4400) return 1'b0;
    return ((t - 4400) / 200) % 2 == 0;
  endfunction

  function automatic lapg_out_t led_color(input lapg_cfg_t c, input lapg_in_t x);
    lapg_out_t   o;
    int unsigned per, el, i, h, sec, pos, d;
    logic [16:0] p, e, t, f8;
    o = '0;
    el = x.elapsed_ms;
    i = x.led_index;
    if (c.mode == MODE_SOS) per = 5400;
    else if (c.mode == MODE_FLASH)
      per = 1000 / ((c.flash_rate_hz < 1) ? 1 : (c.flash_rate_hz > 10) ? 10 : c.flash_rate_hz);
    else per = (c.period_ms == 0) ? 1 : c.period_ms;
    p = 17'((64'(el % per) << 16) / per);
    if (i >= LED_COUNT) return o;
    case (c.mode)
      MODE_SOLID: o = '{c.solid_red, c.solid_green, c.solid_blue};
      MODE_FLASH: if (p < 17'd32768) o = '{c.solid_red, c.solid_green, c.solid_blue};
      MODE_SOS:   if (sos_lit(el % 5400)) o.out_red = 8'd255;
      MODE_FADE_Y: begin
        o.out_red = lvl(17'd65536 - eased(p));
        o.out_green = o.out_red;
      end
      MODE_FADE_RGB: begin
        e = eased(p);
        if (e < FADE_A) begin
          t = seg_frac(e, FADE_A);
          o.out_red = lvl(17'd65536 - t); o.out_green = lvl(t);
        end else if (e < FADE_B) begin
          t = seg_frac(e - FADE_A, FADE_A);
          o.out_green = lvl(17'd65536 - t); o.out_blue = lvl(t);
        end else begin
          t = seg_frac(e - FADE_B, FADE_W3);
          o.out_red = lvl(t); o.out_blue = lvl(17'd65536 - t);
        end
      end
      MODE_RAINBOW: begin
        h = (p + (i * 65536) / LED_COUNT) & 16'hFFFF;
        sec = (h * 6) >> 16;
        f8 = 17'((h * 6) & 16'hFFFF);
        t = sec[0] ? lvl(17'd65536 - f8) : lvl(f8);
        case (sec)
          0: o = '{8'd255, 8'(t), 8'd0};
          1: o = '{8'(t), 8'd255, 8'd0};
          2: o = '{8'd0, 8'd255, 8'(t)};
          3: o = '{8'd0, 8'(t), 8'd255};
          4: o = '{8'(t), 8'd0, 8'd255};
          default: o = '{8'd255, 8'd0, 8'(t)};
        endcase
      end
      MODE_BREATH: begin
        o.out_red = lvl(eased(half_sine(p[15:0])));
        o.out_green = o.out_red;
        o.out_blue = o.out_red;
      end
      MODE_CHASE: begin
        pos = (p * LED_COUNT) >> 16;
        d = (i + LED_COUNT - pos) % LED_COUNT;
        if (d < 5) begin
          o.out_red = 8'(51 * (5 - d));
          o.out_green = 8'(20 * (5 - d));
        end
      end
      MODE_WAVE: begin
        h = (p + ((i * 133509) >> 6)) & 16'hFFFF;
        o.out_red = lvl(half_sine(16'(h)));
        o.out_blue = 8'd255 - o.out_red;
      end
      default: ;
    endcase
    return o;
  endfunction

  // --------------------------------------------------------------------
  // Scoreboard: queue of expected colors plus mismatch bookkeeping.
  // --------------------------------------------------------------------
  class color_board;
    lapg_cfg_t cfg;
    lapg_out_t pending[$];
    int        n_err;
    int        n_checked;

    function void note_input(lapg_in_t x);
      pending.push_back(led_color(cfg, x));
    endfunction

    function void check_result(lapg_out_t got);
      lapg_out_t want;
      n_checked++;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected transaction: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
          got.out_blue !== want.out_blue) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch #%0d: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                   n_checked, want.out_red, want.out_green, want.out_blue,
                   got.out_red, got.out_green, got.out_blue);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  lapg_in_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lapg_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  color_board sb = new();
  int  idle_cycles = 0;   // watchdog: cycles with no transaction on either side
  bit  rx_busy;           // random stalls on/off, toggled per phase

  always #4 clk = ~clk;

  led_animation_pattern_generator_core u_dut (.*);

  // Output side: check each accepted color and run the watchdog.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("watchdog expired, %0d colors outstanding", sb.pending.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stall: per accepted item, a random hold (or none when quiet).
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        n = rx_busy ? $urandom_range(0, 14) : 0;
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // One register write; cfg_valid is dropped before the task returns, so writes never overlap.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:   sb.cfg.mode = val[3:0];
      CFG_PERIOD: sb.cfg.period_ms = val;
      CFG_RED:    sb.cfg.solid_red = val[7:0];
      CFG_GREEN:  sb.cfg.solid_green = val[7:0];
      CFG_BLUE:   sb.cfg.solid_blue = val[7:0];
      CFG_FLASH:  sb.cfg.flash_rate_hz = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One LED transaction; a random gap comes first when gaps is set.
  // valid stays high after acceptance; a gap or drain() drops it.
  task automatic send_led(input logic [5:0] idx, input logic [31:0] ms, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{idx, ms};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input('{idx, ms});
  endtask

  // Stop sending and wait for the pipeline to drain before touching config.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_ms(input int sel);
    case (sel)
      0: return $urandom();
      1: return $urandom_range(0, 20000);
      default: return 32'hFFFF_FFFF - $urandom_range(0, 10000);
    endcase
  endfunction

  initial begin
    logic [3:0] m;
    int ph;
    sb.cfg = '{MODE_SOLID, 16'd2000, 8'd255, 8'd255, 8'd255, 4'd2};
    sb.n_err = 0;
    sb.n_checked = 0;
    rx_busy = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config, field extremes, SOS window edges around 3800..4400.
    send_led(6'd0, 32'd0, 0);
    send_led(6'd63, 32'hFFFF_FFFF, 0);
    drain();
    write_reg(CFG_MODE, MODE_SOS);
    send_led(6'd5, 32'd3799, 0);
    send_led(6'd5, 32'd3800, 0);
    send_led(6'd5, 32'd4399, 0);
    send_led(6'd5, 32'd4400, 0);
    send_led(6'd5, 32'd5399, 0);
    drain();
    // Every mode plus out-of-range modes 10..15, zero period.
    write_reg(CFG_PERIOD, 16'd0);
    for (int k = 0; k < 16; k++) begin
      write_reg(CFG_MODE, 16'(k));
      send_led(6'(k * 4 + 3), 32'h5555_AAAA + k, 0);
      drain();
    end
    drain();
    // Flash rate clamps: 0 and above 10.
    write_reg(CFG_MODE, MODE_FLASH);
    write_reg(CFG_FLASH, 16'd0);
    send_led(6'd1, 32'd700, 0);
    drain();
    write_reg(CFG_FLASH, 16'd15);
    send_led(6'd1, 32'd60, 0);
    drain();

    // Random phases: each picks a fresh config, then a burst of LEDs.
    for (ph = 0; ph < 26; ph++) begin
      drain();
      m = (ph < 20) ? 4'(ph % 10) : 4'($urandom_range(0, 15));
      write_reg(CFG_MODE, m);
      write_reg(CFG_PERIOD, (ph % 5 == 0) ? 16'hFFFF : (ph % 5 == 1) ? 16'd1 :
                            16'($urandom_range(0, 65535)));
      write_reg(CFG_RED,   (ph == 3) ? 16'd0 : 16'($urandom_range(0, 255)));
      write_reg(CFG_GREEN, (ph == 3) ? 16'd255 : 16'($urandom_range(0, 255)));
      write_reg(CFG_BLUE,  16'($urandom_range(0, 255)));
      write_reg(CFG_FLASH, 16'($urandom_range(0, 15)));
      rx_busy = ph[0];
      for (int k = 0; k < N_RANDOM / 26; k++)
        send_led(6'($urandom_range(0, 63)), rand_ms($urandom_range(0, 2)), ph % 3 != 0);
    end

    drain();
    $display("covered %0d colors over all modes, period/flash extremes and random stalls",
             sb.n_checked);
    $display("mismatches: %0d", sb.n_err);
    if (sb.n_err == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[led_animation_pattern_generator_core.f]
rtl/lapg_pkg.sv
rtl/lapg_phase_div.sv
rtl/lapg_wave.sv
rtl/lapg_color.sv
rtl/led_animation_pattern_generator_core.sv
tb/sv/led_animation_pattern_generator_core_test.sv
